// ----- sv/mahs_pkg.sv -----
// ----------------------------------------------------------------------------
// mahs_pkg
// Shared types, constants and lookup functions for the MPEG audio header
// scanner: header field codes, bitrate and sample rate tables, result word.
// ----------------------------------------------------------------------------
package mahs_pkg;

    // Header field codes.
    localparam logic [10:0] SYNC_ONES  = 11'h7FF;
    localparam logic [1:0]  VER_1      = 2'd3;
    localparam logic [1:0]  VER_RSVD   = 2'd1;
    localparam logic [1:0]  LAYER_RSVD = 2'd0;
    localparam logic [3:0]  RATE_FREE  = 4'd0;
    localparam logic [3:0]  RATE_BAD   = 4'd15;
    localparam logic [1:0]  FREQ_RSVD  = 2'd3;
    localparam logic [1:0]  EMPH_RSVD  = 2'd2;
    localparam logic [1:0]  CH_MONO    = 2'd3;

    // Side info lengths in bytes.
    localparam logic [5:0] SIDE_V1_MONO   = 6'd17;
    localparam logic [5:0] SIDE_V1_STEREO = 6'd32;
    localparam logic [5:0] SIDE_V2_MONO   = 6'd9;
    localparam logic [5:0] SIDE_V2_STEREO = 6'd17;

    // Leading tag identifier bytes and the ID3 signature.
    localparam logic [7:0] TAG_ID0 = 8'd88;
    localparam logic [7:0] TAG_ID1 = 8'd105;
    localparam logic [7:0] TAG_ID2 = 8'd110;
    localparam logic [7:0] TAG_ID3 = 8'd103;
    localparam logic [7:0] ID3_C0  = 8'h49;
    localparam logic [7:0] ID3_C1  = 8'h44;
    localparam logic [7:0] ID3_C2  = 8'h33;

    localparam int unsigned TAG_BYTES = 12;

    localparam int unsigned HEAD_KEEP = 9;   // bytes 0..8 are kept; byte 9 is live
    localparam int unsigned HEAD_POS  = 7;   // header offsets checked at once
    localparam int unsigned TAG_KEEP  = TAG_BYTES - 1;

    localparam logic [8:0] RATE_TAB [2][3][16] = '{
        '{ '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
             9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
           '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
             9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
           '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
             9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0} },
        '{ '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
             9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
           '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
             9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
           '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
             9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0} }
    };

    localparam logic [15:0] FREQ_TAB [4][4] = '{
        '{16'd32000, 16'd16000, 16'd8000,  16'd0},
        '{16'd0,     16'd0,     16'd0,     16'd0},
        '{16'd22050, 16'd24000, 16'd16000, 16'd0},
        '{16'd44100, 16'd48000, 16'd32000, 16'd0}
    };

    typedef struct packed {
        logic        found;
        logic [31:0] header_offset;
        logic [1:0]  version_code;
        logic [1:0]  layer_code;
        logic [3:0]  rate_code;
        logic [1:0]  freq_code;
        logic [1:0]  channel_mode;
        logic [8:0]  bitrate_kbps;
        logic [15:0] sample_rate_hz;
        logic        vbr_tag;
        logic        frames_known;
        logic [31:0] frame_count;
    } t_result;

    function automatic logic header_ok(input logic [31:0] h);
        return (h[31:21] == SYNC_ONES) && (h[20:19] != VER_RSVD)
            && (h[18:17] != LAYER_RSVD) && (h[15:12] != RATE_FREE)
            && (h[15:12] != RATE_BAD) && (h[11:10] != FREQ_RSVD)
            && (h[1:0] != EMPH_RSVD);
    endfunction

    function automatic logic [5:0] side_len(input logic [31:0] h);
        logic mono;
        mono = (h[7:6] == CH_MONO);
        if (h[20:19] == VER_1) begin
            return mono ? SIDE_V1_MONO : SIDE_V1_STEREO;
        end
        return mono ? SIDE_V2_MONO : SIDE_V2_STEREO;
    endfunction

    function automatic logic [8:0] rate_lookup(input logic ver_lsb,
                                               input logic [1:0] lay,
                                               input logic [3:0] ri);
        if (lay == LAYER_RSVD) begin
            return 9'd0;
        end
        return RATE_TAB[ver_lsb][lay - 2'd1][ri];
    endfunction

endpackage

// ----- sv/mahs_in_reg.sv -----
// ----------------------------------------------------------------------------
// mahs_in_reg
// Input register: holds one incoming word until the parser consumes it.
// ----------------------------------------------------------------------------
module mahs_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    output logic [7:0] o_data_byte,
    output logic       o_last_byte,
    input  logic       i_take
);

    logic       r_valid;
    logic [7:0] r_data_byte;
    logic       r_last_byte;
    logic       load;

    // The register can refill in the same cycle that its word is consumed.
    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data_byte <= i_data_byte;
            r_last_byte <= i_last_byte;
        end
    end

    assign o_valid     = r_valid;
    assign o_data_byte = r_data_byte;
    assign o_last_byte = r_last_byte;

endmodule

// ----- sv/mahs_parse.sv -----
// ----------------------------------------------------------------------------
// mahs_parse
// Scanner state and the single-pass byte logic: ID3 skip, header search,
// side info skip, tag capture and result formation.
// ----------------------------------------------------------------------------
module mahs_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_out_free,
    output logic              o_take,
    output logic              o_push,
    output mahs_pkg::t_result o_res
);
    import mahs_pkg::*;

    typedef enum logic [1:0] {
        PH_HEAD   = 2'd0,
        PH_SEARCH = 2'd1,
        PH_TAG    = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos;
    logic [31:0] r_window;
    logic [28:0] r_limit, n_limit;
    logic [31:0] r_header, n_header;
    logic [31:0] r_offset, n_offset;
    logic [31:0] r_tag_base, n_tag_base;
    logic [3:0]  r_tcnt, n_tcnt;
    logic [7:0]  r_head [HEAD_KEEP];
    logic [7:0]  r_tag [TAG_KEEP];

    logic [31:0] win;
    logic [3:0]  pos4;
    logic [7:0]  view [HEAD_KEEP + 1];
    logic        is_nine;
    logic        head_done;
    logic        id3;
    logic [27:0] ss;
    logic        hit_any;
    logic [2:0]  hit_off;
    logic [31:0] hit_hdr;
    logic [31:0] cand;
    logic        tag_take;
    logic        tag_full;
    logic        head_wr;
    logic        tag_wr;
    logic        tag_emit;
    logic        produce;
    logic        tag_id_ok;

    assign win      = {r_window[23:0], i_data_byte};
    assign pos4     = r_pos[3:0];
    assign tag_full = (r_tcnt == 4'(TAG_KEEP));
    assign tag_take = ((r_pos - r_tag_base) >= {26'd0, side_len(r_header)});

    // Head bytes as seen this cycle: the live byte stands in at its position.
    always_comb begin
        for (int i = 0; i < int'(HEAD_KEEP); i++) begin
            view[i] = (pos4 == 4'(i)) ? i_data_byte : r_head[i];
        end
        view[HEAD_KEEP] = i_data_byte;
    end

    assign is_nine   = (pos4 == 4'(HEAD_KEEP));
    assign head_done = is_nine || i_last_byte;
    assign id3       = is_nine && (view[0] == ID3_C0) && (view[1] == ID3_C1)
                    && (view[2] == ID3_C2);
    assign ss        = id3 ? {view[6][6:0], view[7][6:0], view[8][6:0], view[9][6:0]}
                           : 28'd0;

    // Check every offset that the head buffer covers; the lowest match wins.
    always_comb begin
        hit_any = 1'b0;
        hit_off = '0;
        hit_hdr = '0;
        cand    = '0;
        for (int o = int'(HEAD_POS) - 1; o >= 0; o--) begin
            cand = {view[o], view[o + 1], view[o + 2], view[o + 3]};
            if ((4'(o + 3) <= pos4) && (ss <= 28'(o)) && header_ok(cand)) begin
                hit_any = 1'b1;
                hit_off = 3'(o);
                hit_hdr = cand;
            end
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_limit    = r_limit;
        n_header   = r_header;
        n_offset   = r_offset;
        n_tag_base = r_tag_base;
        n_tcnt     = r_tcnt;
        head_wr    = 1'b0;
        tag_wr     = 1'b0;
        tag_emit   = 1'b0;
        case (r_phase)
            PH_HEAD: begin
                head_wr = (pos4 < 4'(HEAD_KEEP));
                if (head_done) begin
                    n_limit = {1'b0, ss} + 29'd3;
                    n_phase = PH_SEARCH;
                    if (hit_any) begin
                        n_header   = hit_hdr;
                        n_offset   = {29'd0, hit_off};
                        n_tag_base = {29'd0, hit_off} + 32'd4;
                        n_tcnt     = '0;
                        n_phase    = PH_TAG;
                    end
                end
            end
            PH_SEARCH: begin
                if ((r_pos >= {3'd0, r_limit}) && header_ok(win)) begin
                    n_header   = win;
                    n_offset   = r_pos - 32'd3;
                    n_tag_base = r_pos + 32'd1;
                    n_tcnt     = '0;
                    n_phase    = PH_TAG;
                end
            end
            PH_TAG: begin
                if (tag_take) begin
                    tag_wr = !tag_full;
                    n_tcnt = r_tcnt + 4'd1;
                    if (tag_full) begin
                        tag_emit = 1'b1;
                        n_phase  = PH_DONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign tag_id_ok = (r_tag[0] == TAG_ID0) && (r_tag[1] == TAG_ID1)
                    && (r_tag[2] == TAG_ID2) && (r_tag[3] == TAG_ID3);

    always_comb begin
        o_res = '0;
        if (tag_emit || n_phase == PH_TAG) begin
            o_res.found          = 1'b1;
            o_res.header_offset  = n_offset;
            o_res.version_code   = n_header[20:19];
            o_res.layer_code     = n_header[18:17];
            o_res.rate_code      = n_header[15:12];
            o_res.freq_code      = n_header[11:10];
            o_res.channel_mode   = n_header[7:6];
            o_res.bitrate_kbps   = rate_lookup(n_header[19], n_header[18:17],
                                               n_header[15:12]);
            o_res.sample_rate_hz = FREQ_TAB[n_header[20:19]][n_header[11:10]];
            if (tag_emit && tag_id_ok) begin
                o_res.vbr_tag = 1'b1;
                if (r_tag[7][0]) begin
                    o_res.frames_known = 1'b1;
                    o_res.frame_count  = {r_tag[8], r_tag[9], r_tag[10], i_data_byte};
                end
            end
        end
    end

    // A word that yields no result may pass even while the output is held.
    assign produce = tag_emit || (i_last_byte && n_phase != PH_DONE);
    assign o_take  = i_valid && (i_out_free || !produce);
    assign o_push  = o_take && produce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEAD;
            r_pos      <= '0;
            r_window   <= '0;
            r_limit    <= '0;
            r_header   <= '0;
            r_offset   <= '0;
            r_tag_base <= '0;
            r_tcnt     <= '0;
        end else if (o_take) begin
            if (head_wr) begin
                r_head[pos4] <= i_data_byte;
            end
            if (tag_wr) begin
                r_tag[r_tcnt] <= i_data_byte;
            end
            if (i_last_byte) begin
                r_phase    <= PH_HEAD;
                r_pos      <= '0;
                r_window   <= '0;
                r_limit    <= '0;
                r_header   <= '0;
                r_offset   <= '0;
                r_tag_base <= '0;
                r_tcnt     <= '0;
            end else begin
                r_phase    <= n_phase;
                r_pos      <= r_pos + 32'd1;
                r_window   <= win;
                r_limit    <= n_limit;
                r_header   <= n_header;
                r_offset   <= n_offset;
                r_tag_base <= n_tag_base;
                r_tcnt     <= n_tcnt;
            end
        end
    end

    a_head_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEAD |-> r_pos < 32'd10)
        else $error("head phase ran past the ID3 size field");

    a_tag_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TAG |-> header_ok(r_header))
        else $error("tag phase entered with an invalid header");

    a_tcnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEAD || r_phase == PH_SEARCH) |-> r_tcnt == 4'd0)
        else $error("tag count moved outside the tag phase");

    a_notfound_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !o_res.found) |-> i_last_byte)
        else $error("not-found result before the end of the stream");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_last_byte) |=> (r_phase == PH_HEAD && r_pos == 32'd0))
        else $error("state not cleared after the final byte");

endmodule

// ----- sv/mahs_out_reg.sv -----
// ----------------------------------------------------------------------------
// mahs_out_reg
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module mahs_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mahs_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_stall,
    output mahs_pkg::t_result o_res
);
    import mahs_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- sv/mpeg_audio_header_scanner_core.sv -----
// ----------------------------------------------------------------------------
// mpeg_audio_header_scanner_core
// Scans an audio file byte stream for the first MPEG audio frame header and
// its optional VBR info tag, and reports one summary word per file.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one file byte per word, in file order, with
// i_last_byte set on the final byte. The output channel carries at most one
// result word per file: when the 12-byte tag block after the side info is
// complete, or on the final byte if no result has gone out yet. Bytes after
// the result are consumed and ignored. After the final byte the scanner is
// back in its reset state, ready for the next file.
// Throughput is one byte per clock while the receiver does not stall a held
// result: the parser updates all of its state on each accepted byte, between
// the input register and the result register. The byte that completes a
// result word passes through the input register, then the result register.
// Reset is synchronous and clears the scanner state and both valid flags; no
// clearing pass is needed. While the receiver stalls a held result, bytes that
// cannot yield a result keep flowing; a byte that would yield one waits in the
// input register and the input stalls behind it.
// ----------------------------------------------------------------------------
module mpeg_audio_header_scanner_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_found,
    output logic [31:0] o_header_offset,
    output logic [1:0]  o_version_code,
    output logic [1:0]  o_layer_code,
    output logic [3:0]  o_rate_code,
    output logic [1:0]  o_freq_code,
    output logic [1:0]  o_channel_mode,
    output logic [8:0]  o_bitrate_kbps,
    output logic [15:0] o_sample_rate_hz,
    output logic        o_vbr_tag,
    output logic        o_frames_known,
    output logic [31:0] o_frame_count
);
    import mahs_pkg::*;

    logic       item_valid;
    logic [7:0] item_byte;
    logic       item_last;
    logic       take;
    logic       push;
    logic       out_free;
    t_result    res;
    t_result    out_res;

    mahs_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (item_valid),
        .o_data_byte (item_byte),
        .o_last_byte (item_last),
        .i_take      (take)
    );

    mahs_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (item_valid),
        .i_data_byte (item_byte),
        .i_last_byte (item_last),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_push      (push),
        .o_res       (res)
    );

    mahs_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    assign o_found          = out_res.found;
    assign o_header_offset  = out_res.header_offset;
    assign o_version_code   = out_res.version_code;
    assign o_layer_code     = out_res.layer_code;
    assign o_rate_code      = out_res.rate_code;
    assign o_freq_code      = out_res.freq_code;
    assign o_channel_mode   = out_res.channel_mode;
    assign o_bitrate_kbps   = out_res.bitrate_kbps;
    assign o_sample_rate_hz = out_res.sample_rate_hz;
    assign o_vbr_tag        = out_res.vbr_tag;
    assign o_frames_known   = out_res.frames_known;
    assign o_frame_count    = out_res.frame_count;

endmodule
